/* rtl/sdens_pkg.sv */
package sdens_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int PART_AW       = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int ENTRY_W       = 128;
    localparam int DENSITY_W     = 48;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int ROOT_STEPS    = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_H          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SCALE   = 2'd2;

    localparam logic [6:0]  RST_PARTICLE_COUNT = 7'd0;
    localparam logic [31:0] RST_INV_H          = 32'd65536;
    localparam logic [31:0] RST_KERNEL_SCALE   = 32'd5215;

    localparam logic       MODE_WRITE = 1'b0;
    localparam logic       MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [6:0]  particle_count;
        logic [31:0] inv_h;
        logic [31:0] kernel_scale;
    } t_cfg;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD_I,
        DP_DIFF,
        DP_QX,
        DP_QY,
        DP_QZ,
        DP_SQ0,
        DP_SQ1,
        DP_SQ2,
        DP_ROOT_INIT,
        DP_ROOT_STEP,
        DP_T2,
        DP_T3,
        DP_S2,
        DP_S3,
        DP_KW,
        DP_MLO,
        DP_ACC,
        DP_EMIT
    } t_dp_op;

endpackage

/* rtl/sdens_ram.sv */
module sdens_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sdens_ctrl.sv */
module sdens_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_query,
    input  logic [5:0]                     i_particle_index,
    input  logic [6:0]                     i_count,
    input  logic                           i_out_stall,
    output logic                           o_busy,
    output logic                           o_rd_en,
    output logic [sdens_pkg::PART_AW-1:0]  o_rd_addr,
    output sdens_pkg::t_dp_op              o_cmd,
    output logic                           o_out_valid,
    output logic [5:0]                     o_result_index
);
    import sdens_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LOADI, S_RDJ, S_DIFF, S_QX, S_QY, S_QZ, S_SQ0, S_SQ1, S_SQ2,
        S_RINIT, S_ROOT, S_T2, S_T3, S_S2, S_S3, S_KW, S_MLO, S_ACC, S_EMIT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_j;
    logic [CNT_W-1:0]   r_n;
    logic [4:0]         r_step;
    logic [5:0]         r_qidx;
    logic [5:0]         r_res_idx;
    logic               r_out_valid;
    logic [CNT_W-1:0]   n_j;
    logic               w_slot_free;

    assign n_j         = r_j + CNT_W'(1);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_j         <= '0;
            r_n         <= '0;
            r_step      <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_query) begin
                        r_qidx  <= i_particle_index;
                        r_state <= S_LOADI;
                        if (32'(i_count) > MAX_PARTICLES) begin
                            r_n <= CNT_W'(MAX_PARTICLES);
                        end else begin
                            r_n <= CNT_W'(i_count);
                        end
                    end
                end
                S_LOADI: begin
                    r_j <= '0;
                    if (r_n == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_RDJ;
                    end
                end
                S_RDJ:   r_state <= S_DIFF;
                S_DIFF:  r_state <= S_QX;
                S_QX:    r_state <= S_QY;
                S_QY:    r_state <= S_QZ;
                S_QZ:    r_state <= S_SQ0;
                S_SQ0:   r_state <= S_SQ1;
                S_SQ1:   r_state <= S_SQ2;
                S_SQ2:   r_state <= S_RINIT;
                S_RINIT: begin
                    r_step  <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(ROOT_STEPS - 1)) begin
                        r_state <= S_T2;
                    end
                end
                S_T2:    r_state <= S_T3;
                S_T3:    r_state <= S_S2;
                S_S2:    r_state <= S_S3;
                S_S3:    r_state <= S_KW;
                S_KW:    r_state <= S_MLO;
                S_MLO:   r_state <= S_ACC;
                S_ACC: begin
                    r_j <= n_j;
                    if (n_j == r_n) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_RDJ;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_res_idx   <= r_qidx;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        case (r_state)
            S_LOADI: o_cmd = DP_LOAD_I;
            S_DIFF:  o_cmd = DP_DIFF;
            S_QX:    o_cmd = DP_QX;
            S_QY:    o_cmd = DP_QY;
            S_QZ:    o_cmd = DP_QZ;
            S_SQ0:   o_cmd = DP_SQ0;
            S_SQ1:   o_cmd = DP_SQ1;
            S_SQ2:   o_cmd = DP_SQ2;
            S_RINIT: o_cmd = DP_ROOT_INIT;
            S_ROOT:  o_cmd = DP_ROOT_STEP;
            S_T2:    o_cmd = DP_T2;
            S_T3:    o_cmd = DP_T3;
            S_S2:    o_cmd = DP_S2;
            S_S3:    o_cmd = DP_S3;
            S_KW:    o_cmd = DP_KW;
            S_MLO:   o_cmd = DP_MLO;
            S_ACC:   o_cmd = DP_ACC;
            S_EMIT:  o_cmd = w_slot_free ? DP_EMIT : DP_NOP;
            default: o_cmd = DP_NOP;
        endcase
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_rd_en        = (r_state == S_IDLE) || (r_state == S_RDJ);
    assign o_rd_addr      = (r_state == S_IDLE) ? PART_AW'(i_particle_index)
                                                : PART_AW'(r_j);
    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_res_idx;

endmodule

/* rtl/sdens_dp.sv */
module sdens_dp (
    input  logic                              i_clk,
    input  sdens_pkg::t_dp_op                 i_cmd,
    input  logic [sdens_pkg::ENTRY_W-1:0]     i_entry,
    input  sdens_pkg::t_cfg                   i_cfg,
    output logic [sdens_pkg::DENSITY_W-1:0]   o_density,
    output logic                              o_saturated
);
    import sdens_pkg::*;

    localparam logic [53:0] DENSITY_MAX = 54'((64'd1 << DENSITY_W) - 64'd1);

    logic [31:0] r_ri [3];
    logic [31:0] r_a [3];
    logic [16:0] r_q [3];
    logic [31:0] r_m;
    logic        r_skip;
    logic [35:0] r_sum;
    logic [33:0] r_rem;
    logic [33:0] r_root;
    logic [33:0] r_bit;
    logic [18:0] r_tmp;
    logic [19:0] r_t3;
    logic [19:0] r_w;
    logic [35:0] r_kw;
    logic [47:0] r_clo;
    logic [47:0] r_acc;
    logic        r_sat;
    logic [47:0] r_odens;
    logic        r_osat;

    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic [16:0] w_qv;
    logic [17:0] w_t;
    logic [16:0] w_s;
    logic [34:0] w_trial;
    logic [21:0] w_s3x4;
    logic [19:0] w_s3;
    logic [35:0] w_hi;
    logic [52:0] w_c;
    logic [53:0] w_tot;
    logic [32:0] w_d [3];
    logic [31:0] w_abs [3];

    assign w_qv    = r_root[16:0];
    assign w_t     = 18'(131072) - {1'b0, w_qv};
    assign w_s     = 17'(65536) - w_qv;
    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k]   = {r_ri[k][31], r_ri[k]} - {i_entry[32*k+31], i_entry[32*k +: 32]};
            w_abs[k] = w_d[k][32] ? 32'(-w_d[k]) : w_d[k][31:0];
        end
    end

    always_comb begin
        case (i_cmd)
            DP_QX:   begin w_ma = r_a[0];             w_mb = i_cfg.inv_h;       end
            DP_QY:   begin w_ma = r_a[1];             w_mb = i_cfg.inv_h;       end
            DP_QZ:   begin w_ma = r_a[2];             w_mb = i_cfg.inv_h;       end
            DP_SQ0:  begin w_ma = 32'(r_q[0]);        w_mb = 32'(r_q[0]);       end
            DP_SQ1:  begin w_ma = 32'(r_q[1]);        w_mb = 32'(r_q[1]);       end
            DP_SQ2:  begin w_ma = 32'(r_q[2]);        w_mb = 32'(r_q[2]);       end
            DP_T2:   begin w_ma = 32'(w_t);           w_mb = 32'(w_t);          end
            DP_T3:   begin w_ma = 32'(r_tmp);         w_mb = 32'(w_t);          end
            DP_S2:   begin w_ma = 32'(w_s);           w_mb = 32'(w_s);          end
            DP_S3:   begin w_ma = 32'(r_tmp);         w_mb = 32'(w_s);          end
            DP_KW:   begin w_ma = i_cfg.kernel_scale; w_mb = 32'(r_w);          end
            DP_MLO:  begin w_ma = r_m;                w_mb = r_kw[31:0];        end
            default: begin w_ma = '0;                 w_mb = '0;                end
        endcase
    end

    assign w_prod = 64'(w_ma) * 64'(w_mb);
    assign w_s3   = w_prod[35:16];
    assign w_s3x4 = {w_s3, 2'b00};
    assign w_hi   = 36'(r_m) * 36'(r_kw[35:32]);
    assign w_c    = 53'(r_clo) + {1'b0, w_hi, 16'b0};
    assign w_tot  = 54'(r_acc) + 54'(w_c);

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LOAD_I: begin
                r_ri[0] <= i_entry[31:0];
                r_ri[1] <= i_entry[63:32];
                r_ri[2] <= i_entry[95:64];
                r_acc   <= '0;
                r_sat   <= 1'b0;
            end
            DP_DIFF: begin
                r_a[0] <= w_abs[0];
                r_a[1] <= w_abs[1];
                r_a[2] <= w_abs[2];
                r_m    <= i_entry[127:96];
                r_skip <= 1'b0;
            end
            DP_QX, DP_QY, DP_QZ: begin
                if (|w_prod[63:33]) begin
                    r_skip <= 1'b1;
                end
                case (i_cmd)
                    DP_QX:   r_q[0] <= w_prod[32:16];
                    DP_QY:   r_q[1] <= w_prod[32:16];
                    default: r_q[2] <= w_prod[32:16];
                endcase
            end
            DP_SQ0: r_sum <= w_prod[35:0];
            DP_SQ1, DP_SQ2: r_sum <= r_sum + w_prod[35:0];
            DP_ROOT_INIT: begin
                if (|r_sum[35:34]) begin
                    r_skip <= 1'b1;
                end
                r_rem  <= r_sum[33:0];
                r_root <= '0;
                r_bit  <= 34'h1_0000_0000;
            end
            DP_ROOT_STEP: begin
                if ({1'b0, r_rem} >= w_trial) begin
                    r_rem  <= r_rem - w_trial[33:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            DP_T2, DP_S2: r_tmp <= w_prod[34:16];
            DP_T3: r_t3 <= w_prod[35:16];
            DP_S3: begin
                if (!w_qv[16]) begin
                    if (22'(r_t3) >= w_s3x4) begin
                        r_w <= 20'(22'(r_t3) - w_s3x4);
                    end else begin
                        r_w <= '0;
                    end
                end else begin
                    r_w <= r_t3;
                end
            end
            DP_KW:  r_kw <= w_prod[51:16];
            DP_MLO: r_clo <= w_prod[63:16];
            DP_ACC: begin
                if (!r_skip) begin
                    if (w_tot > DENSITY_MAX) begin
                        r_acc <= DENSITY_MAX[47:0];
                        r_sat <= 1'b1;
                    end else begin
                        r_acc <= w_tot[47:0];
                    end
                end
            end
            DP_EMIT: begin
                r_odens <= r_acc;
                r_osat  <= r_sat;
            end
            default: ;
        endcase
    end

    assign o_density   = r_odens;
    assign o_saturated = r_osat;

endmodule

/* rtl/sph_density_summation.sv */
// channel  valid         stall         payload
// input    i_in_valid    o_in_stall    i_mode i_particle_index i_pos_x/y/z i_mass
// output   o_out_valid   i_out_stall   o_result_index o_density o_saturated
// config   i_cfg_we      (none)        i_cfg_index i_cfg_data
//
// a write item is taken whenever no query is running; a query stalls input while it walks n
// table entries, n the summed entry count, on the shared multiplier and the 17-step square root per pair
// synchronous active-low reset clears control and config; table contents are not reset
// input is taken while a finished result waits; a query completes once the slot frees
module sph_density_summation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [5:0]  i_particle_index,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_mass,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_result_index,
    output logic [47:0] o_density,
    output logic        o_saturated,
    input  logic        i_cfg_we,
    input  logic [sdens_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sdens_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sdens_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_busy;
    logic                 w_accept;
    logic                 w_idx_ok;
    logic                 w_we;
    logic                 w_query;
    logic                 w_rd_en;
    logic [PART_AW-1:0]   w_rd_addr;
    logic [ENTRY_W-1:0]   w_entry;
    t_dp_op               w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.particle_count <= RST_PARTICLE_COUNT;
            r_cfg.inv_h          <= RST_INV_H;
            r_cfg.kernel_scale   <= RST_KERNEL_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PARTICLE_COUNT: r_cfg.particle_count <= i_cfg_data[6:0];
                CFG_INV_H:          r_cfg.inv_h          <= i_cfg_data;
                CFG_KERNEL_SCALE:   r_cfg.kernel_scale   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;
    assign w_idx_ok   = 32'(i_particle_index) < MAX_PARTICLES;
    assign w_we       = w_accept && w_idx_ok && (i_mode == MODE_WRITE);
    assign w_query    = w_accept && w_idx_ok && (i_mode == MODE_QUERY);

    sdens_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTICLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (PART_AW'(i_particle_index)),
        .i_wdata ({i_mass, i_pos_z, i_pos_y, i_pos_x}),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_entry)
    );

    sdens_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_query          (w_query),
        .i_particle_index (i_particle_index),
        .i_count          (r_cfg.particle_count),
        .i_out_stall      (i_out_stall),
        .o_busy           (w_busy),
        .o_rd_en          (w_rd_en),
        .o_rd_addr        (w_rd_addr),
        .o_cmd            (w_cmd),
        .o_out_valid      (o_out_valid),
        .o_result_index   (o_result_index)
    );

    sdens_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_entry     (w_entry),
        .i_cfg       (r_cfg),
        .o_density   (o_density),
        .o_saturated (o_saturated)
    );

endmodule
